// File: hdl/ordered_queue_search_delete_core_assert.svh
// ============================================================================
// Ordered queue assertion macros
// Shorthand for clocked implication checks with a reset guard.
// ============================================================================
`ifndef ORDERED_QUEUE_SEARCH_DELETE_CORE_ASSERT_SVH
`define ORDERED_QUEUE_SEARCH_DELETE_CORE_ASSERT_SVH

// same-cycle implication
`define OQSD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered queue check failed");

// next-cycle implication
`define OQSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered queue check failed");

`endif

// File: hdl/oqsd_pkg.sv
// ============================================================================
// Ordered queue package
// Field widths, opcodes, status codes and the controller command type.
// ============================================================================
`default_nettype none

package oqsd_pkg;

   // fixed field widths
   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd3;

   // result status
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming item and its match vector
      logic execute;   // apply the operation and load the result register
   } cmd_type;

endpackage

`default_nettype wire

// File: hdl/oqsd_req_if.sv
// ============================================================================
// Ordered queue request channel
// Valid/ready channel carrying one opcode and one operand value.
// ============================================================================
`default_nettype none

interface oqsd_req_if;
   logic                                valid;
   logic                                ready;
   logic        [oqsd_pkg::OPCODE_W-1:0] opcode;
   logic signed [oqsd_pkg::VALUE_W-1:0]  item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

`default_nettype wire

// File: hdl/oqsd_rsp_if.sv
// ============================================================================
// Ordered queue response channel
// Valid/ready channel carrying one result per request.
// ============================================================================
`default_nettype none

interface oqsd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [oqsd_pkg::VALUE_W-1:0]  popped_value;
   logic                                hit;
   logic        [oqsd_pkg::STATUS_W-1:0] status;
   logic        [oqsd_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output popped_value, output hit, output status,
                   output occupancy, input ready);
   modport sink   (input valid, input popped_value, input hit, input status,
                   input occupancy, output ready);
endinterface

`default_nettype wire

// File: hdl/oqsd_ctrl.sv
// ============================================================================
// Ordered queue controller
// Two-state sequencer: take an item, then apply it once the result slot frees.
// ============================================================================
`default_nettype none

module oqsd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output oqsd_pkg::cmd_type     cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_EXEC = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // result slot is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hdl/oqsd_dpath.sv
// ============================================================================
// Ordered queue datapath
// Register row of entries with parallel compare, compaction shift and result.
// ============================================================================
`default_nettype none

module oqsd_dpath #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire oqsd_pkg::cmd_type                    cmd,
   input  wire logic        [oqsd_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic signed [oqsd_pkg::VALUE_W-1:0]  req_item_value,
   output logic             [oqsd_pkg::VALUE_W-1:0]  rsp_popped_value,
   output logic                                      rsp_hit,
   output logic             [oqsd_pkg::STATUS_W-1:0] rsp_status,
   output logic             [oqsd_pkg::OCC_W-1:0]    rsp_occupancy
);

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int LVLS  = $clog2(DEPTH);
   localparam int EXT_W = (WIDTH > oqsd_pkg::VALUE_W) ? WIDTH : oqsd_pkg::VALUE_W;

   // entry row, head at index 0
   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [WIDTH-1:0] entry_in [DEPTH];
   logic [WIDTH-1:0] entry_up [DEPTH];
   logic [CW-1:0]    count_ff, count_in;

   // captured item
   logic [oqsd_pkg::OPCODE_W-1:0] op_ff;
   logic [WIDTH-1:0]              val_ff;
   logic [DEPTH-1:0]              match_ff, match_in;

   // result registers
   logic [oqsd_pkg::VALUE_W-1:0]  popped_ff, popped_in;
   logic                          hit_ff, hit_in;
   logic [oqsd_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [oqsd_pkg::OCC_W-1:0]    occ_ff;

   logic signed [EXT_W-1:0] in_ext;
   logic [WIDTH-1:0]        in_val;
   logic [DEPTH-1:0]        tail_vec, shift_vec;
   logic [DEPTH-1:0]        pre [LVLS+1];
   logic                    head_m, tail_m, any_m;
   logic                    empty, full;
   logic                    push_en, shift_en;

   // operand: sign-extend, keep WIDTH bits
   assign in_ext = EXT_W'(req_item_value);
   assign in_val = in_ext[WIDTH-1:0];

   // parallel compare against held entries
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (CW'(i) < count_ff) && (entry_ff[i] == in_val);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         val_ff   <= in_val;
         match_ff <= match_in;
      end
   end

   // inclusive prefix OR of the match vector, log-depth
   assign pre[0] = match_ff;
   genvar k, g;
   generate
      for (k = 0; k < LVLS; k++) begin : g_lvl
         for (g = 0; g < DEPTH; g++) begin : g_bit
            if (g >= (1 << k)) begin : g_or
               assign pre[k+1][g] = pre[k][g] | pre[k][g-(1<<k)];
            end else begin : g_pass
               assign pre[k+1][g] = pre[k][g];
            end
         end
      end
   endgenerate

   // neighbour behind each entry for close-up
   generate
      for (g = 0; g < DEPTH - 1; g++) begin : g_up
         assign entry_up[g] = entry_ff[g+1];
      end
   endgenerate
   assign entry_up[DEPTH-1] = entry_ff[DEPTH-1];

   // tail position decode
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         tail_vec[i] = (CW'(i + 1) == count_ff);
      end
   end

   assign head_m = match_ff[0];
   assign tail_m = |(match_ff & tail_vec);
   assign any_m  = |match_ff;
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CW'(DEPTH));

   // operation decode
   always_comb begin
      push_en   = 1'b0;
      shift_en  = 1'b0;
      shift_vec = '1;
      count_in  = count_ff;
      popped_in = '0;
      hit_in    = 1'b0;
      status_in = oqsd_pkg::STAT_OK;
      case (op_ff)
         oqsd_pkg::OP_PUSH: begin
            if (full) begin
               status_in = oqsd_pkg::STAT_FULL;
            end else begin
               push_en  = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         oqsd_pkg::OP_POP: begin
            if (empty) begin
               status_in = oqsd_pkg::STAT_EMPTY;
            end else begin
               popped_in = oqsd_pkg::VALUE_W'(entry_ff[0]);
               shift_en  = 1'b1;
               count_in  = count_ff - CW'(1);
            end
         end
         oqsd_pkg::OP_SEARCH: begin
            hit_in = any_m;
         end
         oqsd_pkg::OP_DELETE: begin
            if (any_m) begin
               hit_in    = 1'b1;
               shift_en  = 1'b1;
               count_in  = count_ff - CW'(1);
               // tail wins over a middle match, head over both
               shift_vec = (tail_m && !head_m) ? tail_vec : pre[LVLS];
            end
         end
         default: begin
         end
      endcase
   end

   // entry row next values
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
         if (cmd.execute) begin
            if (push_en && (CW'(i) == count_ff)) begin
               entry_in[i] = val_ff;
            end else if (shift_en && shift_vec[i]) begin
               entry_in[i] = entry_up[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         popped_ff <= popped_in;
         hit_ff    <= hit_in;
         status_ff <= status_in;
         occ_ff    <= oqsd_pkg::OCC_W'(count_in);
      end
   end

   assign rsp_popped_value = popped_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

`default_nettype wire

// File: hdl/ordered_queue_search_delete_core.sv
// ============================================================================
// Ordered queue with search and delete
// Bounded first-in first-out queue that also answers search and delete.
// ============================================================================
// Usage:
//   req_ch carries an opcode (push, pop, search, delete) and a value; each
//   transfer on req_ch yields exactly one transfer on rsp_ch, in order.
//   rsp_ch returns the popped value, a hit flag, a status (ok, pop on empty,
//   push on full) and the number of entries held afterwards.
//   The request is captured and applied, and the result is registered.
//   No new request is taken until the last is applied, set by the controller's
//   compare-then-apply sequence; the match vector is registered between them.
//   Delete picks the head if it matches, else the tail, else the first match,
//   and the entries behind the victim close up in the same cycle.
//   Reset empties the queue; entry contents are left as they were.
//   When the receiver stalls, the result is held and one further request may
//   be taken; it waits in the apply step until the result slot frees.
// ============================================================================
`default_nettype none

module ordered_queue_search_delete_core #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   oqsd_req_if.sink    req_ch,
   oqsd_rsp_if.source  rsp_ch
);

   oqsd_pkg::cmd_type cmd;
   logic              req_ready;
   logic              rsp_valid;

   logic [oqsd_pkg::VALUE_W-1:0]  popped_value;
   logic                          hit;
   logic [oqsd_pkg::STATUS_W-1:0] status;
   logic [oqsd_pkg::OCC_W-1:0]    occupancy;

   // sequencer
   oqsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // entry row and result
   oqsd_dpath #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (req_ch.opcode),
      .req_item_value   (req_ch.item_value),
      .rsp_popped_value (popped_value),
      .rsp_hit          (hit),
      .rsp_status       (status),
      .rsp_occupancy    (occupancy)
   );

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.popped_value = popped_value;
   assign rsp_ch.hit          = hit;
   assign rsp_ch.status       = status;
   assign rsp_ch.occupancy    = occupancy;

endmodule

`default_nettype wire

// File: hdl/oqsd_checker.sv
// ============================================================================
// Ordered queue port checker
// Watches the channel ports of the core and flags inconsistent results.
// ============================================================================
`default_nettype none

`include "ordered_queue_search_delete_core_assert.svh"

module oqsd_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [oqsd_pkg::VALUE_W-1:0]  rsp_popped_value,
   input wire logic                          rsp_hit,
   input wire logic [oqsd_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [oqsd_pkg::OCC_W-1:0]    rsp_occupancy
);

   localparam logic [oqsd_pkg::OCC_W-1:0] FULL_OCC = oqsd_pkg::OCC_W'(DEPTH);

   logic                                 rsp_stall;
   logic [oqsd_pkg::VALUE_W+oqsd_pkg::STATUS_W+oqsd_pkg::OCC_W:0] rsp_word;
   logic                                 rsp_refused;
   logic                                 rsp_empty;
   logic                                 rsp_full;
   logic                                 rsp_cleared;

   // shorthand terms for the checks below
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_popped_value, rsp_hit, rsp_status, rsp_occupancy};
   assign rsp_refused = rsp_valid && (rsp_status != oqsd_pkg::STAT_OK);
   assign rsp_empty   = rsp_valid && (rsp_status == oqsd_pkg::STAT_EMPTY);
   assign rsp_full    = rsp_valid && (rsp_status == oqsd_pkg::STAT_FULL);
   assign rsp_cleared = (rsp_occupancy == '0) && (rsp_popped_value == '0);

   // a stalled result stays put
   `OQSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // no back-to-back request transfers
   `OQSD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // a refused push or pop never reports a hit
   `OQSD_ASSERT_SAME(a_err_no_hit, clock, reset, rsp_refused, !rsp_hit)

   // pop on empty leaves the queue empty
   `OQSD_ASSERT_SAME(a_empty_occ, clock, reset, rsp_empty, rsp_cleared)

   // push on full leaves the queue full
   `OQSD_ASSERT_SAME(a_full_occ, clock, reset, rsp_full, rsp_occupancy == FULL_OCC)

endmodule

bind ordered_queue_search_delete_core oqsd_checker #(
   .DEPTH (DEPTH)
) u_oqsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_popped_value (rsp_ch.popped_value),
   .rsp_hit          (rsp_ch.hit),
   .rsp_status       (rsp_ch.status),
   .rsp_occupancy    (rsp_ch.occupancy)
);

`default_nettype wire
